/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the policer table.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define TBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked assertion that also holds across reset.
`define TBP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/tbp_pkg.sv */
// ----------------------------------------------------------------------------
// tbp_pkg
// Types, codes and widths of the token bucket policer table.
// ----------------------------------------------------------------------------
package tbp_pkg;

  localparam int KEY_W      = 64;
  localparam int COST_W     = 30;
  localparam int NOW_W      = 48;
  localparam int RATE_W     = 30;
  localparam int TOK_W      = 40;
  localparam int CNT_W      = 64;
  localparam int LIVE_OUT_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 30;
  localparam int MILLI      = 1000;
  // time delta is multiplied in two slices of this width
  localparam int PART_W     = 20;

  localparam logic [1:0] ACT_ALLOW     = 2'd0;
  localparam logic [1:0] ACT_QUERY     = 2'd1;
  localparam logic [1:0] ACT_CLEAR_ONE = 2'd2;
  localparam logic [1:0] ACT_CLEAR_ALL = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_REFILL_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_TOKENS = 2'd1;

  typedef struct packed {
    logic [1:0]        action;
    logic [KEY_W-1:0]  key_hash;
    logic [COST_W-1:0] cost;
    logic [NOW_W-1:0]  now_ms;
  } tbp_req_t;

  typedef struct packed {
    logic                  granted;
    logic [TOK_W-1:0]      tokens_milli;
    logic [CNT_W-1:0]      allowed_total;
    logic [CNT_W-1:0]      denied_total;
    logic [LIVE_OUT_W-1:0] live_slots;
  } tbp_rsp_t;

  // one table entry as stored in the RAM
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [TOK_W-1:0] tokens;
    logic [NOW_W-1:0] stamp_ms;
  } tbp_entry_t;

  localparam int ENTRY_W = $bits(tbp_entry_t);

  // stage loads for the refill pipeline
  typedef struct packed {
    logic ld_read;
    logic ld_mul;
    logic ld_fill;
  } tbp_ctl_t;

  // slot state after the touch, before any debit
  typedef struct packed {
    logic             was_valid;
    logic             hit;
    logic [TOK_W-1:0] tokens;
  } tbp_touch_t;

  function automatic logic [TOK_W-1:0] to_milli(input logic [COST_W-1:0] v);
    return TOK_W'(v) * TOK_W'(MILLI);
  endfunction

endpackage

/* hw/rtl/tbp_ram.sv */
// ----------------------------------------------------------------------------
// tbp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/tbp_refill.sv */
// ----------------------------------------------------------------------------
// tbp_refill
// Three-stage touch pipeline: decode the stored entry, multiply the elapsed
// time by the refill rate in two slices, then add and saturate at the burst.
// ----------------------------------------------------------------------------
module tbp_refill import tbp_pkg::*; (
  input  logic              clk,
  input  tbp_ctl_t          ctl,
  input  tbp_entry_t        slot,
  input  logic [KEY_W-1:0]  key_hash,
  input  logic [NOW_W-1:0]  now_ms,
  input  logic [RATE_W-1:0] refill_rate,
  input  logic [TOK_W-1:0]  cap,
  output tbp_touch_t        touch
);

  localparam int PROD_W = PART_W + RATE_W;
  localparam int SUM_W  = 2 * PART_W + RATE_W + 1;

  logic              hit;
  logic              was_valid;
  logic              advance;
  logic              full;
  logic [NOW_W-1:0]  dt;
  logic [TOK_W-1:0]  tokens_old;
  logic [PROD_W-1:0] prod_lo;
  logic [PROD_W-1:0] prod_hi;
  logic              overflow;
  logic [SUM_W-1:0]  sum;
  logic              saturate;
  logic [TOK_W-1:0]  tokens_new;

  always_ff @(posedge clk) begin
    if (ctl.ld_read) begin
      hit        <= slot.valid && (slot.key == key_hash);
      was_valid  <= slot.valid;
      advance    <= now_ms > slot.stamp_ms;
      dt         <= now_ms - slot.stamp_ms;
      tokens_old <= slot.tokens;
      full       <= slot.tokens >= cap;
    end
    if (ctl.ld_mul) begin
      prod_lo  <= PROD_W'(dt[PART_W-1:0]) * PROD_W'(refill_rate);
      prod_hi  <= PROD_W'(dt[2*PART_W-1:PART_W]) * PROD_W'(refill_rate);
      // any delta at or above 2^40 with a nonzero rate overfills the bucket
      overflow <= (|dt[NOW_W-1:2*PART_W]) && (|refill_rate);
    end
    if (ctl.ld_fill) begin
      touch <= '{was_valid: was_valid, hit: hit, tokens: tokens_new};
    end
  end

  always_comb begin
    sum      = SUM_W'(tokens_old) + SUM_W'(prod_lo) + (SUM_W'(prod_hi) << PART_W);
    saturate = full || overflow || (sum > SUM_W'(cap));
    // empty or colliding slot starts full; no refill unless time advanced
    if (!hit) begin
      tokens_new = cap;
    end else if (!advance) begin
      tokens_new = tokens_old;
    end else if (saturate) begin
      tokens_new = cap;
    end else begin
      tokens_new = sum[TOK_W-1:0];
    end
  end

endmodule

/* hw/rtl/token_bucket_policer_table.sv */
// ----------------------------------------------------------------------------
// token_bucket_policer_table
// Per-key token bucket policer over a direct-mapped table in one RAM.
// ----------------------------------------------------------------------------
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | tbp_req_t (action, key, cost, time)
//   rsp     | out       | rsp_valid / rsp_stall  | tbp_rsp_t (grant, tokens, counts)
//   cfg     | in        | cfg_we                 | cfg_index, cfg_data
//
// One request is in flight at a time: read, decode, multiply, refill, write back.
// The result is registered through the read, multiply, fill and update states, and
// the next request is taken only once the block is back in idle.
// Reset, and every clear-all request, sweep all TABLE_SLOTS entries one entry per
// cycle with req_stall high. A stalled result holds in the output register; the
// request in flight waits in its write-back state until the register frees up.
// ----------------------------------------------------------------------------
module token_bucket_policer_table import tbp_pkg::*; #(
  parameter int TABLE_SLOTS = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  tbp_req_t              req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output tbp_rsp_t              rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W  = $clog2(TABLE_SLOTS);
  localparam int LIVE_W = $clog2(TABLE_SLOTS + 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_READ   = 6'b000010,
    ST_MUL    = 6'b000100,
    ST_FILL   = 6'b001000,
    ST_UPDATE = 6'b010000,
    ST_SWEEP  = 6'b100000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [RATE_W-1:0]   refill_rate;
  logic [RATE_W-1:0]   burst_tokens;
  tbp_req_t            item;
  logic [TOK_W-1:0]    cost_milli;
  logic                cost_ok;
  logic [IDX_W-1:0]    sweep_idx;
  logic [LIVE_W-1:0]   live_count;
  logic [LIVE_W-1:0]   live_next;
  logic [CNT_W-1:0]    allowed_count;
  logic [CNT_W-1:0]    allowed_next;
  logic [CNT_W-1:0]    denied_count;
  logic [CNT_W-1:0]    denied_next;

  logic                accept;
  logic                rsp_free;
  logic                commit;
  logic [TOK_W-1:0]    cap;
  logic                granted;
  logic [TOK_W-1:0]    tokens_final;
  tbp_ctl_t            ctl;
  tbp_touch_t          touch;
  tbp_entry_t          rd_entry;
  tbp_entry_t          ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign commit    = (state == ST_UPDATE) && rsp_free;
  assign cap       = to_milli(burst_tokens);
  assign rd_entry  = tbp_entry_t'(ram_rdata);

  assign ctl = '{ld_read: state == ST_READ, ld_mul: state == ST_MUL,
                 ld_fill: state == ST_FILL};

  tbp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_SLOTS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(req.key_hash[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  tbp_refill u_refill (
    .clk        (clk),
    .ctl        (ctl),
    .slot       (rd_entry),
    .key_hash   (item.key_hash),
    .now_ms     (item.now_ms),
    .refill_rate(refill_rate),
    .cap        (cap),
    .touch      (touch)
  );

  // allow decision and debit
  always_comb begin
    granted      = (item.action == ACT_ALLOW) && cost_ok && (touch.tokens >= cost_milli);
    tokens_final = granted ? (touch.tokens - cost_milli) : touch.tokens;
    allowed_next = allowed_count + CNT_W'(granted);
    denied_next  = denied_count + CNT_W'((item.action == ACT_ALLOW) && !granted);
    live_next    = live_count;
    unique case (item.action)
      ACT_ALLOW, ACT_QUERY: begin
        if (!touch.was_valid) begin
          live_next = live_count + LIVE_W'(1);
        end
      end
      ACT_CLEAR_ONE: begin
        if (touch.was_valid) begin
          live_next = live_count - LIVE_W'(1);
        end
      end
      default: begin
        live_next = '0;
      end
    endcase
  end

  // table write: sweep, or write back the touched entry
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = item.key_hash[IDX_W-1:0];
    ram_wdata = '0;
    unique case (state)
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_idx;
      end
      ST_UPDATE: begin
        if (rsp_free && (item.action != ACT_CLEAR_ALL)) begin
          ram_we = 1'b1;
          if (item.action != ACT_CLEAR_ONE) begin
            ram_wdata = '{valid: 1'b1, key: item.key_hash, tokens: tokens_final,
                          stamp_ms: item.now_ms};
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_READ;
        end
      end
      ST_READ:  state_next = ST_MUL;
      ST_MUL:   state_next = ST_FILL;
      ST_FILL:  state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (rsp_free) begin
          state_next = (item.action == ACT_CLEAR_ALL) ? ST_SWEEP : ST_IDLE;
        end
      end
      ST_SWEEP: begin
        if (sweep_idx == IDX_W'(TABLE_SLOTS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_SWEEP;
      sweep_idx     <= '0;
      refill_rate   <= RATE_W'(1);
      burst_tokens  <= RATE_W'(1);
      live_count    <= '0;
      allowed_count <= '0;
      denied_count  <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      state <= state_next;
      // wraps back to zero at the end of each sweep
      if (state == ST_SWEEP) begin
        sweep_idx <= sweep_idx + IDX_W'(1);
      end
      if (cfg_we) begin
        if (cfg_index == CFG_REFILL_RATE) begin
          refill_rate <= cfg_data;
        end else if (cfg_index == CFG_BURST_TOKENS) begin
          burst_tokens <= cfg_data;
        end
      end
      if (commit) begin
        live_count    <= live_next;
        allowed_count <= allowed_next;
        denied_count  <= denied_next;
      end
      if (rsp_free) begin
        rsp_valid <= (state == ST_UPDATE);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item       <= req;
      cost_milli <= to_milli(req.cost);
      cost_ok    <= (req.cost != '0) && (req.cost <= burst_tokens);
    end
    if (commit) begin
      rsp.granted       <= granted;
      rsp.tokens_milli  <= (item.action == ACT_ALLOW || item.action == ACT_QUERY) ?
                           tokens_final : '0;
      rsp.allowed_total <= allowed_next;
      rsp.denied_total  <= denied_next;
      rsp.live_slots    <= LIVE_OUT_W'(live_next);
    end
  end

endmodule

/* hw/rtl/tbp_checker.sv */
// ----------------------------------------------------------------------------
// tbp_checker
// Port-level assertions for the token bucket policer table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tbp_checker import tbp_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_stall,
  input tbp_req_t              req,
  input logic                  rsp_valid,
  input logic                  rsp_stall,
  input tbp_rsp_t              rsp,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CNT_W-1:0] last_allowed;
  logic             cfg_seen;

  // track the grant count of the last delivered beat
  always_ff @(posedge clk) begin
    if (rst) begin
      last_allowed <= '0;
    end else if (rsp_valid && !rsp_stall) begin
      last_allowed <= rsp.allowed_total;
    end
  end

  assign cfg_seen = cfg_we && (cfg_index == CFG_REFILL_RATE) && (cfg_data == '0) &&
                    req_valid && (req.cost == '0);

  `TBP_ASSERT(a_one_in_flight, (req_valid && !req_stall) |=> req_stall, "second request taken while one is in flight")
  `TBP_ASSERT(a_rsp_from_busy, $rose(rsp_valid) |-> $past(req_stall), "result appeared while the block was idle")
  `TBP_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)), "stalled result beat changed")
  `TBP_ASSERT(a_grant_count, (rsp_valid && !rsp_stall && !cfg_seen) |-> (rsp.allowed_total == last_allowed + CNT_W'(rsp.granted)), "grant count does not follow the granted flag")
  `TBP_ASSERT_ALWAYS(a_reset_busy, rst |=> (req_stall && !rsp_valid), "block not busy and silent after reset")

endmodule

bind token_bucket_policer_table tbp_checker u_tbp_checker (.*);
